FILE: design/lsahc_pkg.sv
// Shared constants and helpers for the LRU set-associative hit counter.
// No dependencies; every other design file refers to this package by scope.
package lsahc_pkg;

    localparam int ADDR_W     = 64;
    localparam int COUNT_W    = 48;
    localparam int HASH_SHIFT = 13;
    localparam int DEF_SETS   = 8192;
    localparam int DEF_WAYS   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // true when n is a power of two (one counts)
    function automatic bit is_pow2(input int n);
        return ((n & (n - 1)) == 0);
    endfunction

    // index width for n sets, at least one bit
    function automatic int set_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: design/lsahc_req_if.sv
// Request channel: one access address per transfer.
// Depends on lsahc_pkg for the address width.
interface lsahc_req_if;
    logic                         valid;
    logic                         ready;
    logic [lsahc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

FILE: design/lsahc_rsp_if.sv
// Response channel: hit flag and running hit/miss totals.
// Depends on lsahc_pkg for the counter width.
interface lsahc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lsahc_pkg::COUNT_W-1:0] hit_total;
    logic [lsahc_pkg::COUNT_W-1:0] miss_total;

    modport source (output valid, output hit, output hit_total, output miss_total,
                    input ready);
    modport sink   (input valid, input hit, input hit_total, input miss_total,
                    output ready);
endinterface

FILE: design/lru_set_assoc_hit_counter.sv
// Set-associative true-LRU hit counter.
// req carries one access address per request; rsp returns, per request, the
// hit flag and the saturating hit and miss totals including that access.
// The set is (address ^ (address >> 13)) mod SETS; each set is one memory row
// of WAYS 64-bit tags, most recent first.
// With a power-of-two SETS a request reads the set row, then updates it and
// writes it back; the response is registered and valid from the cycle after
// that. Other set counts first pass the set index through the byte-serial
// remainder unit.
// One request is in flight at a time: req.ready is high only while the block
// waits for a request.
// Reset: counters clear at once, then a clearing pass writes every set row to
// zero, one row per cycle, with req.ready low. Zeroed tags mean address 0
// hits on first use.
// A stalled rsp holds its result; a request may be taken while it waits, but
// its row update waits until the pending response is taken.
// Depends on lsahc_pkg, lsahc_req_if, lsahc_rsp_if and the lsahc_* modules.
module lru_set_assoc_hit_counter #(
    parameter int SETS = lsahc_pkg::DEF_SETS,
    parameter int WAYS = lsahc_pkg::DEF_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    lsahc_req_if.sink   req,
    lsahc_rsp_if.source rsp
);

    localparam int SET_W = lsahc_pkg::set_width(SETS);
    localparam int ROW_W = WAYS * lsahc_pkg::ADDR_W;
    localparam bit POW2  = lsahc_pkg::is_pow2(SETS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_LOOKUP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SET_W-1:0]                 clr_reg, clr_next;
    logic [SET_W-1:0]                 idx_reg, idx_next;
    logic [lsahc_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [lsahc_pkg::COUNT_W-1:0]    hit_count_reg, hit_count_next;
    logic [lsahc_pkg::COUNT_W-1:0]    miss_count_reg, miss_count_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             hit_out_reg, hit_out_next;

    logic                 accept;
    logic                 advance;
    logic                 idx_done;
    logic [SET_W-1:0]     set_idx;
    logic                 wr_en;
    logic [SET_W-1:0]     wr_idx;
    logic [ROW_W-1:0]     wr_row;
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     new_row;
    logic                 lookup_hit;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign advance   = (state_reg == ST_LOOKUP) && (!out_valid_reg || rsp.ready);

    lsahc_set_index #(
        .SETS (SETS)
    ) u_set_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .address (req.address),
        .done    (idx_done),
        .set_idx (set_idx)
    );

    lsahc_tag_ram #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_row (wr_row),
        .rd_en  (rd_en),
        .rd_idx (set_idx),
        .rd_row (rd_row)
    );

    lsahc_lru_update #(
        .WAYS (WAYS)
    ) u_lru_update (
        .old_row (rd_row),
        .address (addr_reg),
        .new_row (new_row),
        .hit     (lookup_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        hit_out_next    = hit_out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_row          = new_row;
        rd_en           = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_idx   = clr_reg;
                wr_row   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next = req.address;
                    if (POW2)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (idx_done)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (advance)
                begin
                    wr_en          = 1'b1;
                    hit_out_next   = lookup_hit;
                    out_valid_next = 1'b1;
                    if (lookup_hit)
                    begin
                        if (hit_count_reg != lsahc_pkg::COUNT_MAX)
                        begin
                            hit_count_next = hit_count_reg + 1'b1;
                        end
                    end
                    else if (miss_count_reg != lsahc_pkg::COUNT_MAX)
                    begin
                        miss_count_next = miss_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (rd_en)
        begin
            idx_next = set_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        hit_out_reg <= hit_out_next;
    end

    // counters only move together with a response load, so they track rsp
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = hit_out_reg;
    assign rsp.hit_total  = hit_count_reg;
    assign rsp.miss_total = miss_count_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while another is in flight");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("tag row read and write in the same cycle");

    a_update_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("row update without a response");

    a_hit_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (hit_count_reg >= $past(hit_count_reg)))
        else $error("hit total went backwards");

endmodule

FILE: design/lsahc_set_index.sv
// Set index unit: (address ^ (address >> 13)) mod SETS.
// Power-of-two set counts use a mask; other counts reduce one byte per cycle.
// Depends on lsahc_pkg.
module lsahc_set_index #(
    parameter int SETS = lsahc_pkg::DEF_SETS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [lsahc_pkg::ADDR_W-1:0]               address,
    output logic                                       done,
    output logic [lsahc_pkg::set_width(SETS)-1:0]      set_idx
);

    localparam int SET_W = lsahc_pkg::set_width(SETS);

    logic [lsahc_pkg::ADDR_W-1:0] hash;
    assign hash = address ^ (address >> lsahc_pkg::HASH_SHIFT);

    generate
        if (lsahc_pkg::is_pow2(SETS)) begin : g_mask
            // index is ready in the cycle the address is presented
            assign done = 1'b0;
            if (SETS == 1) begin : g_one
                assign set_idx = '0;
            end
            else begin : g_bits
                assign set_idx = hash[SET_W-1:0];
            end
        end
        else begin : g_reduce
            localparam int RW    = SET_W + 1;
            localparam int NSTEP = lsahc_pkg::ADDR_W / 8;
            localparam int CW    = $clog2(NSTEP);
            localparam logic [RW-1:0] SETS_R = RW'(SETS);
            localparam logic [CW-1:0] LAST   = CW'(NSTEP - 1);

            logic [lsahc_pkg::ADDR_W-1:0] hash_reg, hash_next;
            logic [SET_W-1:0]             rem_reg, rem_next;
            logic [CW-1:0]                cnt_reg, cnt_next;
            logic                         busy_reg, busy_next;
            logic                         done_reg, done_next;

            // remainder stays below SETS, so 2r+1 stays below 2*SETS
            always_comb
            begin
                logic [RW-1:0] r;
                logic [7:0]    digit;
                hash_next = hash_reg;
                rem_next  = rem_reg;
                cnt_next  = cnt_reg;
                busy_next = busy_reg;
                done_next = 1'b0;
                digit     = hash_reg[lsahc_pkg::ADDR_W-1 -: 8];
                r         = {1'b0, rem_reg};
                for (int b = 7; b >= 0; b--)
                begin
                    r = {r[RW-2:0], digit[b]};
                    if (r >= SETS_R)
                    begin
                        r = r - SETS_R;
                    end
                end
                if (start)
                begin
                    hash_next = hash;
                    rem_next  = '0;
                    cnt_next  = '0;
                    busy_next = 1'b1;
                end
                else if (busy_reg)
                begin
                    hash_next = hash_reg << 8;
                    rem_next  = r[SET_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == LAST)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                end
            end

            always_ff @(posedge clk)
            begin
                hash_reg <= hash_next;
                rem_reg  <= rem_next;
            end

            assign done    = done_reg;
            assign set_idx = rem_reg;
        end
    endgenerate

endmodule

FILE: design/lsahc_tag_ram.sv
// Tag store: one row per set holding WAYS tags, one write and one read port,
// registered read data. Depends on lsahc_pkg.
module lsahc_tag_ram #(
    parameter int SETS = lsahc_pkg::DEF_SETS,
    parameter int WAYS = lsahc_pkg::DEF_WAYS
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [lsahc_pkg::set_width(SETS)-1:0]    wr_idx,
    input  logic [WAYS*lsahc_pkg::ADDR_W-1:0]        wr_row,
    input  logic                                     rd_en,
    input  logic [lsahc_pkg::set_width(SETS)-1:0]    rd_idx,
    output logic [WAYS*lsahc_pkg::ADDR_W-1:0]        rd_row
);

    localparam int ROW_W = WAYS * lsahc_pkg::ADDR_W;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_idx];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

FILE: design/lsahc_lru_update.sv
// LRU row update: moves the address to the front and shifts older tags back
// up to the first match, or out of the last way on a miss. Depends on lsahc_pkg.
module lsahc_lru_update #(
    parameter int WAYS = lsahc_pkg::DEF_WAYS
) (
    input  logic [WAYS*lsahc_pkg::ADDR_W-1:0] old_row,
    input  logic [lsahc_pkg::ADDR_W-1:0]      address,
    output logic [WAYS*lsahc_pkg::ADDR_W-1:0] new_row,
    output logic                              hit
);

    localparam int TW = lsahc_pkg::ADDR_W;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] seen;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = (old_row[i*TW +: TW] == address);
        end
        // seen[i]: some way in front of i already matched
        seen[0] = 1'b0;
        for (int i = 1; i < WAYS; i++)
        begin
            seen[i] = seen[i-1] | match[i-1];
        end
        new_row[0 +: TW] = address;
        for (int i = 1; i < WAYS; i++)
        begin
            new_row[i*TW +: TW] = seen[i] ? old_row[i*TW +: TW] : old_row[(i-1)*TW +: TW];
        end
        hit = |match;
    end

endmodule

FILE: dv/lru_set_assoc_hit_counter_tb.sv
`timescale 1ns / 100ps
// Testbench for lru_set_assoc_hit_counter: directed and random access streams,
// each response checked against a behavioral mirror of the LRU tag sets.
// Depends on lsahc_pkg, lsahc_req_if, lsahc_rsp_if and the design sources.
module lru_set_assoc_hit_counter_tb;

    localparam int ADDR_W       = lsahc_pkg::ADDR_W;
    localparam int COUNT_W      = lsahc_pkg::COUNT_W;
    localparam int HASH_SHIFT   = lsahc_pkg::HASH_SHIFT;
    localparam logic [COUNT_W-1:0] COUNT_MAX = lsahc_pkg::COUNT_MAX;
    localparam int SETS_N       = lsahc_pkg::DEF_SETS;
    localparam int WAYS_N       = lsahc_pkg::DEF_WAYS;
    localparam int HI_W         = ADDR_W - HASH_SHIFT;
    localparam int IDLE_PCT     = 10;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int HOT_SETS     = 4;
    localparam int HOT_TAGS     = 24;   // a few more than WAYS_N so hot sets also evict
    localparam int TAIL_CYCLES  = 30;
    localparam int DRAIN_CYCLES = 5000;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
    } lookup_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lsahc_req_if req ();
    lsahc_rsp_if rsp ();

    lru_set_assoc_hit_counter #(
        .SETS(SETS_N),
        .WAYS(WAYS_N)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    // mirror of the tag rows, zero at reset like the block's store
    bit [ADDR_W-1:0]  tag_mirror [SETS_N*WAYS_N];
    bit [COUNT_W-1:0] hits_seen;
    bit [COUNT_W-1:0] misses_seen;

    lookup_result_t    expected_results [$];
    logic [ADDR_W-1:0] pending_addrs [$];
    logic [ADDR_W-1:0] recent_addrs [$];
    int                errors;
    int                accepted;

    int unsigned       hot_sets [HOT_SETS];
    logic [HI_W-1:0]   hot_tags [HOT_SETS][HOT_TAGS];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH t=%0t: %s", $time, msg);
    endtask

    // no idling while requests 300..599 go through
    function automatic bit stall_now();
        if (accepted >= 300 && accepted < 600)
            return 1'b0;
        return ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void model_access(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] folded;
        logic [ADDR_W-1:0] carry;
        logic [ADDR_W-1:0] prev;
        int                base;
        bit                found;
        lookup_result_t    r;
        folded = a ^ (a >> HASH_SHIFT);
        base   = int'(folded % 64'(SETS_N)) * WAYS_N;
        carry  = a;
        found  = 1'b0;
        for (int w = 0; w < WAYS_N; w++)
        begin
            prev = tag_mirror[base + w];
            tag_mirror[base + w] = carry;
            if (prev == a)
            begin
                found = 1'b1;
                break;
            end
            carry = prev;
        end
        if (found)
        begin
            if (hits_seen != COUNT_MAX)
                hits_seen++;
        end
        else if (misses_seen != COUNT_MAX)
            misses_seen++;
        r.hit        = found;
        r.hit_total  = hits_seen;
        r.miss_total = misses_seen;
        expected_results.push_back(r);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [HI_W-1:0] rand_hi();
        logic [ADDR_W-1:0] r;
        r = rand_addr();
        return r[HI_W-1:0];
    endfunction

    // address with the given upper bits that lands in set_idx
    // (SETS_N is a power of two no larger than 2**HASH_SHIFT)
    function automatic logic [ADDR_W-1:0] addr_in_set(input logic [31:0] set_idx,
                                                      input logic [HI_W-1:0] hi);
        logic [ADDR_W-1:0] a;
        a = {hi, {HASH_SHIFT{1'b0}}};
        a[HASH_SHIFT-1:0] = set_idx[HASH_SHIFT-1:0] ^ a[2*HASH_SHIFT-1:HASH_SHIFT];
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int                sel;
        int                k;
        logic [ADDR_W-1:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            k = $urandom_range(0, HOT_SETS - 1);
            a = addr_in_set(hot_sets[k], hot_tags[k][$urandom_range(0, HOT_TAGS - 1)]);
        end
        else if (sel < 75 && recent_addrs.size() > 0)
            a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        else if (sel < 95)
            a = rand_addr();
        else
        begin
            case ($urandom_range(0, 3))
                0:       a = '0;
                1:       a = '1;
                2:       a = 64'd1 << $urandom_range(0, ADDR_W - 1);
                default: a = ~(64'd1 << $urandom_range(0, ADDR_W - 1));
            endcase
        end
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 8)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.address <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                model_access(req.address);
                accepted++;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_addrs.size() > 0 && !stall_now())
                begin
                    req.valid   <= 1'b1;
                    req.address <= pending_addrs.pop_front();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        lookup_result_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch($sformatf("hit got %0b expected %0b",
                                                  rsp.hit, want.hit));
                    if (rsp.hit_total !== want.hit_total)
                        report_mismatch($sformatf("hit_total got %0d expected %0d",
                                                  rsp.hit_total, want.hit_total));
                    if (rsp.miss_total !== want.miss_total)
                        report_mismatch($sformatf("miss_total got %0d expected %0d",
                                                  rsp.miss_total, want.miss_total));
                end
            end
            rsp.ready <= !stall_now();
        end
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] fill [WAYS_N+1];
        int                drain;

        hot_sets[0] = 0;
        hot_sets[1] = SETS_N - 1;
        hot_sets[2] = $urandom_range(1, SETS_N - 2);
        hot_sets[3] = $urandom_range(1, SETS_N - 2);
        foreach (hot_tags[k, j])
            hot_tags[k][j] = rand_hi();

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // address zero hits on a cleared store; all ones misses, then hits
        pending_addrs.push_back('0);
        pending_addrs.push_back('1);
        pending_addrs.push_back('1);
        pending_addrs.push_back('0);
        // one past the ways into one set: first is evicted, second sits in the last way
        for (int i = 0; i <= WAYS_N; i++)
        begin
            fill[i] = addr_in_set(5, HI_W'({rand_hi() >> 8, 8'(i + 1)}));
            pending_addrs.push_back(fill[i]);
        end
        pending_addrs.push_back(fill[1]);
        pending_addrs.push_back(fill[0]);
        pending_addrs.push_back(64'd1 << (ADDR_W - 1));
        pending_addrs.push_back('0);

        while (pending_addrs.size() < TOTAL_ITEMS)
            pending_addrs.push_back(pick_address());

        while (pending_addrs.size() != 0 || req.valid)
            @(posedge clk);
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived",
                                      expected_results.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // timeout covers the clearing pass and every request, even when stalled
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
